// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, disabled while reset is high
`define TTQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, checked during reset as well
`define TTQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTQ_ASSERT(lbl, clk, rst, prop, msg)
`define TTQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/ttq_pkg.sv =====
// ---------------------------------------------------------------------------
// ttq_pkg
// Types and constants of the timed task queue.
// ---------------------------------------------------------------------------
package ttq_pkg;

   localparam int TIME_W    = 32;
   localparam int ID_W      = 16;
   localparam int HANDLE_W  = 32;
   localparam int OCC_W     = 5;
   localparam int CMD_W     = 2;
   localparam int REQ_DATA_W = 80;   // due_time, task_id, payload
   localparam int RSP_DATA_W = 88;   // out_time, out_id, out_payload, occupancy, pad
   localparam int RSP_USER_W = 2;    // ok, evicted

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_REPLACE = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_POP     = 2'd3
   } cmd_type;

   // one stored task; due_time in the low bits
   typedef struct packed {
      logic [HANDLE_W-1:0] payload;
      logic [ID_W-1:0]     task_id;
      logic [TIME_W-1:0]   due_time;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                ok;
      logic                evicted;
      logic [TIME_W-1:0]   out_time;
      logic [ID_W-1:0]     out_id;
      logic [HANDLE_W-1:0] out_payload;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic earlier;   // first operand is before second, wrap-aware
      logic id_hit;    // stored id equals command id
   } cmp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIND_RD,
      ST_FIND_CK,
      ST_DROP_RD,
      ST_DROP_WR,
      ST_POP_RD,
      ST_POP_CK,
      ST_PLACE,
      ST_TAIL_RD,
      ST_TAIL_CK,
      ST_HEAD_RD,
      ST_HEAD_CK,
      ST_LAST_RD,
      ST_LAST_CK,
      ST_POS_RD,
      ST_POS_CK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/ttq_ram.sv =====
// ---------------------------------------------------------------------------
// ttq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ttq_cmp.sv =====
// ---------------------------------------------------------------------------
// ttq_cmp
// Shared compare unit: wrap-aware time order and id match.
// ---------------------------------------------------------------------------
module ttq_cmp (
   input  logic [ttq_pkg::TIME_W-1:0] new_time,
   input  logic [ttq_pkg::ID_W-1:0]   new_id,
   input  ttq_pkg::entry_type         ent,
   input  logic                       ent_first,  // 1: ent before new, 0: new before ent
   output ttq_pkg::cmp_type           res
);

   logic [ttq_pkg::TIME_W-1:0] op_a;
   logic [ttq_pkg::TIME_W-1:0] op_b;
   logic [ttq_pkg::TIME_W-1:0] diff;

   always_comb begin
      op_a = ent_first ? ent.due_time : new_time;
      op_b = ent_first ? new_time : ent.due_time;
      diff = op_a - op_b;
      res.earlier = diff[ttq_pkg::TIME_W-1];
      res.id_hit  = (ent.task_id == new_id);
   end

endmodule

// ===== rtl/ttq_ctrl.sv =====
// ---------------------------------------------------------------------------
// ttq_ctrl
// Command sequencer: id search, slot shifting and sorted placement.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttq_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttq_pkg::cmd_type   cmd,
   input  ttq_pkg::entry_type item,
   input  logic               out_free,
   output logic               done,
   output ttq_pkg::rsp_type   res
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ttq_pkg::state_type state_ff, state_in;
   ttq_pkg::cmd_type   cmd_ff, cmd_in;
   ttq_pkg::entry_type item_ff, item_in;
   ttq_pkg::entry_type pop_ff, pop_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               ok_ff, ok_in;
   logic               ev_ff, ev_in;
   logic               rm_ff, rm_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   ttq_pkg::entry_type          wr_data;
   logic [AW-1:0]               rd_addr;
   logic [ttq_pkg::ENTRY_W-1:0] rd_data;
   ttq_pkg::entry_type          rd_ent;
   ttq_pkg::cmp_type            cmp;
   logic                        ent_first;

   logic [CW-1:0]               idx_inc;
   logic [CW-1:0]               idx_dec;
   logic [CW-1:0]               last;
   logic                        full;
   logic [CW+ttq_pkg::OCC_W-1:0] occ_ext;

   ttq_ram #(
      .WIDTH (ttq_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ent    = ttq_pkg::entry_type'(rd_data);
   assign ent_first = (state_ff == ttq_pkg::ST_TAIL_CK) || (state_ff == ttq_pkg::ST_POS_CK);

   ttq_cmp u_cmp (
      .new_time  (item_ff.due_time),
      .new_id    (item_ff.task_id),
      .ent       (rd_ent),
      .ent_first (ent_first),
      .res       (cmp)
   );

   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);
   assign last    = cnt_ff - CW'(1);
   assign full    = (cnt_ff >= CW'(DEPTH));
   assign occ_ext = {{ttq_pkg::OCC_W{1'b0}}, cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttq_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff  <= cmd_in;
      item_ff <= item_in;
      pop_ff  <= pop_in;
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      ok_ff   <= ok_in;
      ev_ff   <= ev_in;
      rm_ff   <= rm_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      item_in   = item_ff;
      pop_in    = pop_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      ok_in     = ok_ff;
      ev_in     = ev_ff;
      rm_in     = rm_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = rd_ent;
      rd_addr   = idx_ff[AW-1:0];
      req_ready = 1'b0;
      done      = 1'b0;

      unique case (state_ff)
         ttq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in  = cmd;
               item_in = item;
               pop_in  = '0;
               ok_in   = 1'b0;
               ev_in   = 1'b0;
               rm_in   = 1'b0;
               idx_in  = '0;
               unique case (cmd)
                  ttq_pkg::CMD_POP: begin
                     state_in = (cnt_ff == '0) ? ttq_pkg::ST_DONE : ttq_pkg::ST_POP_RD;
                  end
                  ttq_pkg::CMD_REMOVE: begin
                     if (item.task_id == '0 || cnt_ff == '0) begin
                        state_in = ttq_pkg::ST_DONE;
                     end else begin
                        state_in = ttq_pkg::ST_FIND_RD;
                     end
                  end
                  ttq_pkg::CMD_INSERT: begin
                     if (full) begin
                        state_in = ttq_pkg::ST_DONE;
                     end else if (item.task_id != '0 && cnt_ff != '0) begin
                        state_in = ttq_pkg::ST_FIND_RD;
                     end else begin
                        state_in = ttq_pkg::ST_PLACE;
                     end
                  end
                  ttq_pkg::CMD_REPLACE: begin
                     if (item.task_id != '0 && cnt_ff != '0) begin
                        state_in = ttq_pkg::ST_FIND_RD;
                     end else begin
                        state_in = ttq_pkg::ST_PLACE;
                     end
                  end
                  default: state_in = ttq_pkg::ST_DONE;
               endcase
            end
         end

         // linear id search
         ttq_pkg::ST_FIND_RD: begin
            if (idx_ff == cnt_ff) begin
               state_in = (cmd_ff == ttq_pkg::CMD_REMOVE) ? ttq_pkg::ST_DONE
                                                          : ttq_pkg::ST_PLACE;
            end else begin
               state_in = ttq_pkg::ST_FIND_CK;
            end
         end
         ttq_pkg::ST_FIND_CK: begin
            if (cmp.id_hit) begin
               rm_in    = 1'b1;
               ok_in    = (cmd_ff == ttq_pkg::CMD_REMOVE);
               state_in = ttq_pkg::ST_DROP_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = ttq_pkg::ST_FIND_RD;
            end
         end

         // close the gap at idx: move entries one slot toward the head
         ttq_pkg::ST_DROP_RD: begin
            rd_addr = idx_inc[AW-1:0];
            if (idx_inc == cnt_ff) begin
               cnt_in = last;
               if (cmd_ff == ttq_pkg::CMD_REMOVE || cmd_ff == ttq_pkg::CMD_POP) begin
                  state_in = ttq_pkg::ST_DONE;
               end else begin
                  state_in = ttq_pkg::ST_PLACE;
               end
            end else begin
               state_in = ttq_pkg::ST_DROP_WR;
            end
         end
         ttq_pkg::ST_DROP_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_inc;
            state_in = ttq_pkg::ST_DROP_RD;
         end

         ttq_pkg::ST_POP_RD: begin
            rd_addr  = '0;
            state_in = ttq_pkg::ST_POP_CK;
         end
         ttq_pkg::ST_POP_CK: begin
            pop_in   = rd_ent;
            ok_in    = 1'b1;
            idx_in   = '0;
            state_in = ttq_pkg::ST_DROP_RD;
         end

         ttq_pkg::ST_PLACE: begin
            if (full && !rm_ff) begin
               state_in = ttq_pkg::ST_TAIL_RD;
            end else if (cnt_ff == '0) begin
               pos_in   = '0;
               idx_in   = cnt_ff;
               state_in = ttq_pkg::ST_SHIFT_RD;
            end else begin
               state_in = ttq_pkg::ST_HEAD_RD;
            end
         end

         // full queue: drop the new task or evict the tail
         ttq_pkg::ST_TAIL_RD: begin
            rd_addr  = last[AW-1:0];
            state_in = ttq_pkg::ST_TAIL_CK;
         end
         ttq_pkg::ST_TAIL_CK: begin
            if (cmp.earlier) begin
               state_in = ttq_pkg::ST_DONE;
            end else begin
               cnt_in   = last;
               ev_in    = 1'b1;
               state_in = ttq_pkg::ST_PLACE;
            end
         end

         ttq_pkg::ST_HEAD_RD: begin
            rd_addr  = '0;
            state_in = ttq_pkg::ST_HEAD_CK;
         end
         ttq_pkg::ST_HEAD_CK: begin
            if (cmp.earlier) begin
               pos_in   = '0;
               idx_in   = cnt_ff;
               state_in = ttq_pkg::ST_SHIFT_RD;
            end else begin
               state_in = ttq_pkg::ST_LAST_RD;
            end
         end
         ttq_pkg::ST_LAST_RD: begin
            rd_addr  = last[AW-1:0];
            state_in = ttq_pkg::ST_LAST_CK;
         end
         ttq_pkg::ST_LAST_CK: begin
            if (!cmp.earlier) begin
               pos_in   = cnt_ff;
               idx_in   = cnt_ff;
               state_in = ttq_pkg::ST_SHIFT_RD;
            end else begin
               idx_in   = '0;
               state_in = ttq_pkg::ST_POS_RD;
            end
         end

         // first entry not before the new task
         ttq_pkg::ST_POS_RD: begin
            if (idx_ff == cnt_ff) begin
               pos_in   = cnt_ff;
               state_in = ttq_pkg::ST_SHIFT_RD;
            end else begin
               state_in = ttq_pkg::ST_POS_CK;
            end
         end
         ttq_pkg::ST_POS_CK: begin
            if (cmp.earlier) begin
               idx_in   = idx_inc;
               state_in = ttq_pkg::ST_POS_RD;
            end else begin
               pos_in   = idx_ff;
               idx_in   = cnt_ff;
               state_in = ttq_pkg::ST_SHIFT_RD;
            end
         end

         // open a slot at pos: move entries one slot toward the tail
         ttq_pkg::ST_SHIFT_RD: begin
            rd_addr = idx_dec[AW-1:0];
            if (idx_ff == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[AW-1:0];
               wr_data  = item_ff;
               cnt_in   = cnt_ff + CW'(1);
               ok_in    = 1'b1;
               state_in = ttq_pkg::ST_DONE;
            end else begin
               state_in = ttq_pkg::ST_SHIFT_WR;
            end
         end
         ttq_pkg::ST_SHIFT_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_dec;
            state_in = ttq_pkg::ST_SHIFT_RD;
         end

         ttq_pkg::ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ttq_pkg::ST_IDLE;
            end
         end

         default: state_in = ttq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      res.ok          = ok_ff;
      res.evicted     = ev_ff;
      res.out_time    = pop_ff.due_time;
      res.out_id      = pop_ff.task_id;
      res.out_payload = pop_ff.payload;
      res.occupancy   = occ_ext[ttq_pkg::OCC_W-1:0];
   end

   `TTQ_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (cnt_ff == '0), "count not cleared by reset")
   `TTQ_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(DEPTH), "count above depth")
   `TTQ_ASSERT(a_shift_room, clock, reset,
      (state_ff == ttq_pkg::ST_SHIFT_WR) |-> (cnt_ff < CW'(DEPTH)), "shift into full queue")
   `TTQ_ASSERT(a_idle_hold, clock, reset,
      (state_ff == ttq_pkg::ST_IDLE) |=> $stable(cnt_ff), "count moved without a command")

endmodule

// ===== rtl/timed_task_queue.sv =====
// ---------------------------------------------------------------------------
// timed_task_queue
// Time-sorted queue of timed tasks with insert, replace, remove and pop.
// ---------------------------------------------------------------------------
// One command beat enters on req_*, exactly one result beat leaves on rsp_*.
// Commands: insert, insert_replace (same nonzero id replaced, tail evicted
// when full), remove by id, pop_next (head returned on rsp_tdata).
// Tasks sit in one RAM ordered from head (slot 0) to tail; a compare unit
// (wrap-aware 32-bit time order plus id match) is reused each step.
// Each RAM access presents the address, then uses the registered read data.
// A command that needs no RAM access goes from idle straight to the final
// step; a pop reads the head and shifts every entry one slot toward the head;
// an insert may search by id, evict the tail, then find the slot and shift.
// req_tready rises in the cycle after the result is registered and is high
// only between commands.
// A finished result waits in the rsp register; the next command is taken
// while it waits, and the sequencer holds in its final step only if the
// previous result still has not been taken.
// Reset empties the queue at once (count cleared, no RAM sweep) and drops
// any pending result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module timed_task_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // due_time [31:0], task_id [47:32], payload [79:48]
   input  logic [ttq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd [1:0]
   input  logic [ttq_pkg::CMD_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_time [31:0], out_id [47:32], out_payload [79:48], occupancy [84:80]
   output logic [ttq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // ok [0], evicted [1]
   output logic [ttq_pkg::RSP_USER_W-1:0]      rsp_tuser
);

   ttq_pkg::entry_type req_item;
   ttq_pkg::rsp_type   res;
   ttq_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               done;

   // unpack the command beat
   assign req_item = ttq_pkg::entry_type'(req_tdata);

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   ttq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (ttq_pkg::cmd_type'(req_tuser)),
      .item      (req_item),
      .out_free  (out_free),
      .done      (done),
      .res       (res)
   );

   always_comb begin
      rsp_in       = done ? res : rsp_ff;
      rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ff.evicted, rsp_ff.ok};
   assign rsp_tdata  = {3'b000, rsp_ff.occupancy, rsp_ff.out_payload,
                        rsp_ff.out_id, rsp_ff.out_time};

   // a finished command always lands in the result register
   `TTQ_ASSERT(a_done_shows, clock, reset, done |=> rsp_tvalid, "result beat lost")
   // never overwrite a result that has not been taken
   `TTQ_ASSERT(a_no_overwrite, clock, reset,
      (rsp_valid_ff && !rsp_tready) |-> !done, "result overwritten")
   // a command is taken only when no earlier command is in flight
   `TTQ_ASSERT(a_one_cmd, clock, reset,
      (req_tvalid && req_tready) |=> !req_tready, "command taken while busy")

endmodule

// ===== sim/ttq_checker.sv =====
// ---------------------------------------------------------------------------
// ttq_checker
// Watches the command and result streams of the timed task queue, keeps its
// own copy of the time-sorted queue and compares every result beat with the
// oldest predicted result. Reports the running failure count and the number
// of results still owed.
// ---------------------------------------------------------------------------
module ttq_checker
   import ttq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int                    errors,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow queue, head in slot 0
   logic [TIME_W-1:0]   slot_time   [DEPTH];
   logic [ID_W-1:0]     slot_id     [DEPTH];
   logic [HANDLE_W-1:0] slot_handle [DEPTH];
   int                  held;
   rsp_type             pending_results [$];
   int                  fail_count;

   // wrap-aware: a is due before b
   function automatic bit is_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

   function automatic void close_gap(input int pos);
      if (pos >= held) return;
      for (int k = pos; k + 1 < held; k++) begin
         slot_time[k]   = slot_time[k+1];
         slot_id[k]     = slot_id[k+1];
         slot_handle[k] = slot_handle[k+1];
      end
      held--;
   endfunction

   function automatic bit cancel_id(input logic [ID_W-1:0] id);
      if (id == '0 || held == 0) return 1'b0;
      for (int k = 0; k < held; k++) begin
         if (slot_id[k] == id) begin
            close_gap(k);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit schedule(input logic [TIME_W-1:0] t, input logic [ID_W-1:0] id,
                                   input logic [HANDLE_W-1:0] h, inout logic ev);
      bit freed;
      int pos;
      freed = cancel_id(id);
      if (held >= DEPTH && !freed) begin
         // full: a task due after the tail is dropped, else the tail goes
         if (is_before(slot_time[held-1], t)) return 1'b0;
         held--;
         ev = 1'b1;
      end
      if (held == 0 || is_before(t, slot_time[0]))
         pos = 0;
      else if (!is_before(t, slot_time[held-1]))
         pos = held;
      else begin
         pos = 0;
         while (pos < held && is_before(slot_time[pos], t)) pos++;
      end
      for (int k = held; k > pos; k--) begin
         slot_time[k]   = slot_time[k-1];
         slot_id[k]     = slot_id[k-1];
         slot_handle[k] = slot_handle[k-1];
      end
      slot_time[pos]   = t;
      slot_id[pos]     = id;
      slot_handle[pos] = h;
      held++;
      return 1'b1;
   endfunction

   function automatic rsp_type next_result(input cmd_type cmd, input logic [TIME_W-1:0] t,
                                           input logic [ID_W-1:0] id,
                                           input logic [HANDLE_W-1:0] h);
      rsp_type r;
      logic    ev;
      r  = '0;
      ev = 1'b0;
      case (cmd)
         CMD_INSERT: begin
            if (held < DEPTH) r.ok = schedule(t, id, h, ev);
         end
         CMD_REPLACE: begin
            r.ok = schedule(t, id, h, ev);
         end
         CMD_REMOVE: begin
            r.ok = cancel_id(id);
         end
         CMD_POP: begin
            if (held > 0) begin
               r.ok          = 1'b1;
               r.out_time    = slot_time[0];
               r.out_id      = slot_id[0];
               r.out_payload = slot_handle[0];
               close_gap(0);
            end
         end
         default: ;
      endcase
      r.evicted   = ev;
      r.occupancy = OCC_W'(held);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         held = 0;
         pending_results.delete();
      end else begin
         // result first: it can never belong to a command taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tuser[0], rsp_tuser[1], rsp_tdata[31:0], rsp_tdata[47:32],
                    rsp_tdata[79:48], rsp_tdata[84:80]};
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, expected none, got %0h", $time, seen);
            end else begin
               want = pending_results.pop_front();
               check_field("ok", 32'(want.ok), 32'(seen.ok));
               check_field("evicted", 32'(want.evicted), 32'(seen.evicted));
               check_field("out_time", want.out_time, seen.out_time);
               check_field("out_id", 32'(want.out_id), 32'(seen.out_id));
               check_field("out_payload", want.out_payload, seen.out_payload);
               check_field("occupancy", 32'(want.occupancy), 32'(seen.occupancy));
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(next_result(cmd_type'(req_tuser), req_tdata[31:0],
                                                  req_tdata[47:32], req_tdata[79:48]));
      end
      errors      <= fail_count;
      outstanding <= pending_results.size();
   end

endmodule

// ===== sim/timed_task_queue_tb.sv =====
// ---------------------------------------------------------------------------
// timed_task_queue_tb
// Stimulus and verdict for the timed task queue. A directed opening covers
// empty and full queues, extreme field values, id replacement, eviction and
// dropped inserts; random commands follow in fill, churn and drain blocks.
// Three idle profiles are run; ttq_checker does all prediction and compare.
// ---------------------------------------------------------------------------
module timed_task_queue_tb;
   import ttq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side
   localparam int DRAIN_WAIT  = 200;    // idle wait after the last result, before the verdict

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // due_time, task_id, payload
   logic [CMD_W-1:0]      req_tuser  = '0;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // out_time, out_id, out_payload, occupancy
   logic [RSP_USER_W-1:0] rsp_tuser;         // ok, evicted

   int errors;
   int outstanding;
   int snd_idle_pct = 9;
   int rcv_idle_pct = 66;
   int stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timed_task_queue #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ttq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .errors      (errors),
      .outstanding (outstanding)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);

   // watchdog: no beat on either side for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Each call starts right after a rising edge and returns at the edge that
   // accepted the beat, so tvalid stays high across back-to-back commands.
   task automatic send_cmd(input cmd_type cmd, input logic [TIME_W-1:0] t,
                           input logic [ID_W-1:0] id, input logic [HANDLE_W-1:0] h);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {h, id, t};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender holds off until every result owed has come back
   task automatic wait_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // ids: mostly a small pool so replace/remove hit, some anonymous, some wide
   function automatic logic [ID_W-1:0] task_ident;
      int p;
      p = $urandom_range(99);
      if (p < 10) return '0;
      if (p < 85) return ID_W'($urandom_range(1, 20));
      return ID_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // times: clustered near a base (ties, real ordering), sometimes far or random
   function automatic logic [TIME_W-1:0] task_time(input logic [TIME_W-1:0] base);
      int p;
      p = $urandom_range(99);
      if (p < 75) return base + $urandom_range(0, 63);
      if (p < 90) return base + $urandom_range(0, 1 << 20);
      return $urandom;
   endfunction

   task automatic run_random(input int n);
      int                mode;
      int                p;
      logic [TIME_W-1:0] base;
      cmd_type           cmd;
      for (int i = 0; i < n; i++) begin
         // new block every 40 beats: 0 fill, 1 churn, 2 drain
         if (i % 40 == 0) begin
            mode = $urandom_range(2);
            base = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                            : $urandom;
         end
         p = $urandom_range(99);
         case (mode)
            0: begin
               if (p < 60)      cmd = CMD_INSERT;
               else if (p < 80) cmd = CMD_REPLACE;
               else if (p < 90) cmd = CMD_REMOVE;
               else             cmd = CMD_POP;
            end
            1: begin
               if (p < 25)      cmd = CMD_INSERT;
               else if (p < 55) cmd = CMD_REPLACE;
               else if (p < 75) cmd = CMD_REMOVE;
               else             cmd = CMD_POP;
            end
            default: begin
               if (p < 15)      cmd = CMD_INSERT;
               else if (p < 30) cmd = CMD_REPLACE;
               else if (p < 50) cmd = CMD_REMOVE;
               else             cmd = CMD_POP;
            end
         endcase
         send_cmd(cmd, task_time(base), task_ident(), $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty queue, extremes, id replacement ---
      send_cmd(CMD_POP,     32'd0,        16'd0,      32'd0);         // pop on empty
      send_cmd(CMD_REMOVE,  32'd0,        16'd5,      32'd0);         // remove on empty
      send_cmd(CMD_INSERT,  32'd0,        16'd0,      32'd0);
      send_cmd(CMD_INSERT,  32'hFFFF_FFFF, 16'hFFFF,  32'hFFFF_FFFF); // wraps before 0
      send_cmd(CMD_INSERT,  32'd100,      16'hFFFF,   32'h1234_5678); // same id, replaced
      send_cmd(CMD_REMOVE,  32'd0,        16'd0,      32'd0);         // id 0 never matches
      send_cmd(CMD_REMOVE,  32'd0,        16'd1234,   32'd0);         // miss

      // fill to DEPTH with ascending times, ids 1..14
      for (int i = 1; i <= DEPTH - 2; i++)
         send_cmd(CMD_INSERT, 32'd200 + 32'(10 * i), ID_W'(i), $urandom);

      // --- directed: full queue ---
      send_cmd(CMD_INSERT,  32'd50,       16'd99,     32'hA5A5_A5A5); // full, fails
      send_cmd(CMD_INSERT,  32'd55,       16'd3,      32'h0BAD_F00D); // full, even with id
      send_cmd(CMD_REPLACE, 32'd9999,     16'd98,     32'h1111_1111); // after tail, dropped
      send_cmd(CMD_REPLACE, 32'd205,      16'd97,     32'h2222_2222); // evicts tail
      send_cmd(CMD_REPLACE, 32'd1,        16'd7,      32'h3333_3333); // same id, no eviction
      send_cmd(CMD_REMOVE,  32'd0,        16'd9,      32'd0);         // hit in the middle
      send_cmd(CMD_POP,     32'd0,        16'd0,      32'd0);

      wait_results;
      run_random(170);

      // --- sender mostly idle, receiver mostly ready ---
      wait_results;
      snd_idle_pct = 66;
      rcv_idle_pct = 9;
      run_random(180);

      // --- no idling on either side ---
      wait_results;
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_random(170);

      wait_results;
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ttq_pkg.sv
rtl/ttq_ram.sv
rtl/ttq_cmp.sv
rtl/ttq_ctrl.sv
rtl/timed_task_queue.sv
sim/ttq_checker.sv
sim/timed_task_queue_tb.sv
